// ----- rtl/core/rsr_pkg.sv -----
`timescale 1ns / 1ps
// Package for the rank select and remove block: sizes, field widths,
// operation codes and the controller state type. No dependencies.
package rsr_pkg;

   // Number of list positions held in the value store.
   localparam int LIST_DEPTH  = 1024;

   // The count tree covers the next power of two at or above the list depth.
   localparam int LEVELS      = $clog2(LIST_DEPTH);
   localparam int TREE_LEAVES = 2 ** LEVELS;
   localparam int TREE_DEPTH  = 2 * TREE_LEAVES;

   // Derived widths.
   localparam int POS_W   = LEVELS;
   localparam int NODE_W  = LEVELS + 1;
   localparam int CNT_W   = $clog2(TREE_LEAVES + 1);
   localparam int VADDR_W = $clog2(LIST_DEPTH);

   // Fixed field widths of the ports.
   localparam int VALUE_W = 64;
   localparam int INDEX_W = 10;
   localparam int RANK_W  = 11;
   localparam int LEN_W   = 11;

   // Width used when ranks are compared against counts.
   localparam int CMP_W = (RANK_W > CNT_W) ? RANK_W : CNT_W;

   // Operation codes carried by req_func.
   typedef enum logic {
      FUNC_LOAD   = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DESCEND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

endpackage

// ----- rtl/core/rank_select_and_remove.sv -----
`timescale 1ns / 1ps
// Rank select and remove top level; uses rsr_pkg and rsr_ram.
// Load transaction: one per cycle while the block is idle, no result.
// Remove transaction: one tree read per level down and one read-modify-write per node up;
// the block takes no new request until the result has been handed to the output register.
// Rank error: no tree access; the request goes straight to emitting its result.
// Reset and every csr write clear the whole count tree, with req_ready low throughout.
module rank_select_and_remove
   import rsr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Request channel.
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic [INDEX_W-1:0]        req_load_index,
   input  logic signed [VALUE_W-1:0] req_load_value,
   input  logic [RANK_W-1:0]         req_rank,
   // Response channel.
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_removed_value,
   output logic [INDEX_W-1:0]        rsp_removed_position,
   output logic                      rsp_rank_error,
   // Configuration register.
   input  logic                      csr_write_en,
   input  logic [LEN_W-1:0]          csr_write_data
);

   // Control and payload registers.
   state_type           state_ff, state_in;
   logic [NODE_W-1:0]   clear_addr_ff, clear_addr_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    half_ff, half_in;
   logic [CMP_W-1:0]    k_ff, k_in;
   logic                err_ff, err_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    total_ff, total_in;
   logic [LEN_W-1:0]    list_len_ff, list_len_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [INDEX_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic                rsp_err_ff, rsp_err_in;

   // Memory ports.
   logic                tree_wr_en;
   logic [NODE_W-1:0]   tree_wr_addr;
   logic [CNT_W-1:0]    tree_wr_data;
   logic                tree_rd_en;
   logic [NODE_W-1:0]   tree_rd_addr;
   logic [CNT_W-1:0]    tree_rd_data;
   logic                val_wr_en;
   logic [VADDR_W-1:0]  val_wr_addr;
   logic                val_rd_en;
   logic [VADDR_W-1:0]  val_rd_addr;
   logic [VALUE_W-1:0]  val_rd_data;

   // Descent datapath.
   logic [CNT_W-1:0]    len_eff;
   logic [CNT_W-1:0]    present;
   logic                rank_bad;
   logic                load_ok;
   logic [CNT_W-1:0]    mid;
   logic [CNT_W-1:0]    lim;
   logic [CNT_W-1:0]    cap;
   logic [CNT_W-1:0]    lp;
   logic                go_left;
   logic [NODE_W-1:0]   step_node;
   logic [CNT_W-1:0]    step_lo;
   logic [CMP_W-1:0]    step_k;
   logic                last_level;

   // Count tree memory: number of removed positions under each node.
   rsr_ram #(
      .WIDTH (CNT_W),
      .DEPTH (TREE_DEPTH)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (tree_wr_en),
      .wr_addr (tree_wr_addr),
      .wr_data (tree_wr_data),
      .rd_en   (tree_rd_en),
      .rd_addr (tree_rd_addr),
      .rd_data (tree_rd_data)
   );

   // Value store memory.
   rsr_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (LIST_DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (req_load_value),
      .rd_en   (val_rd_en),
      .rd_addr (val_rd_addr),
      .rd_data (val_rd_data)
   );

   // Effective length and the number of entries still present.
   assign len_eff  = (32'(list_len_ff) < LIST_DEPTH) ? CNT_W'(list_len_ff)
                                                     : CNT_W'(LIST_DEPTH);
   assign present  = (total_ff <= len_eff) ? len_eff - total_ff : '0;
   assign rank_bad = (req_rank == '0) || (CMP_W'(req_rank) > CMP_W'(present));
   assign load_ok  = (32'(req_load_index) < LIST_DEPTH);

   // One tree level: present entries in the left half decide the branch.
   assign mid        = lo_ff + half_ff;
   assign lim        = (mid < len_eff) ? mid : len_eff;
   assign cap        = (lim > lo_ff) ? lim - lo_ff : '0;
   assign lp         = (cap > tree_rd_data) ? cap - tree_rd_data : '0;
   assign go_left    = (k_ff <= CMP_W'(lp));
   assign step_node  = {node_ff[NODE_W-2:0], ~go_left};
   assign step_lo    = go_left ? lo_ff : mid;
   assign step_k     = go_left ? k_ff : k_ff - CMP_W'(lp);
   assign last_level = (half_ff == CNT_W'(1));

   // Next state, memory control and register updates.
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      node_in       = node_ff;
      lo_in         = lo_ff;
      half_in       = half_ff;
      k_in          = k_ff;
      err_in        = err_ff;
      pos_in        = pos_ff;
      total_in      = total_ff;
      list_len_in   = list_len_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_err_in    = rsp_err_ff;
      tree_wr_en    = 1'b0;
      tree_wr_addr  = '0;
      tree_wr_data  = '0;
      tree_rd_en    = 1'b0;
      tree_rd_addr  = '0;
      val_wr_en     = 1'b0;
      val_wr_addr   = VADDR_W'(req_load_index);
      val_rd_en     = 1'b0;
      val_rd_addr   = '0;
      req_ready     = (state_ff == ST_IDLE);

      unique case (state_ff)
         // Zero the count tree one node per cycle.
         ST_CLEAR: begin
            tree_wr_en    = 1'b1;
            tree_wr_addr  = clear_addr_ff;
            clear_addr_in = clear_addr_ff + NODE_W'(1);
            if (clear_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         // Take a transaction; a remove with a valid rank starts by reading the root's left child.
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_LOAD) begin
                  val_wr_en = load_ok;
               end else begin
                  k_in    = CMP_W'(req_rank);
                  node_in = NODE_W'(1);
                  lo_in   = '0;
                  half_in = CNT_W'(TREE_LEAVES / 2);
                  err_in  = rank_bad;
                  if (rank_bad) begin
                     state_in = ST_EMIT;
                  end else begin
                     tree_rd_en   = 1'b1;
                     tree_rd_addr = NODE_W'(2);
                     state_in     = ST_DESCEND;
                  end
               end
            end
         end
         // Walk down one level per cycle.
         ST_DESCEND: begin
            node_in    = step_node;
            lo_in      = step_lo;
            k_in       = step_k;
            half_in    = half_ff >> 1;
            tree_rd_en = 1'b1;
            if (last_level) begin
               pos_in       = POS_W'(step_lo);
               tree_rd_addr = step_node;
               val_rd_en    = 1'b1;
               val_rd_addr  = VADDR_W'(step_lo);
               state_in     = ST_UPDATE;
            end else begin
               tree_rd_addr = {step_node[NODE_W-2:0], 1'b0};
            end
         end
         // Increment the leaf and each ancestor, reading the parent meanwhile.
         ST_UPDATE: begin
            tree_wr_en   = 1'b1;
            tree_wr_addr = node_ff;
            tree_wr_data = tree_rd_data + CNT_W'(1);
            if (node_ff == NODE_W'(1)) begin
               total_in = total_ff + CNT_W'(1);
               state_in = ST_EMIT;
            end else begin
               tree_rd_en   = 1'b1;
               tree_rd_addr = node_ff >> 1;
               node_in      = node_ff >> 1;
            end
         end
         // Hand the result to the output register once it is free.
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = err_ff ? '0 : val_rd_data;
               rsp_pos_in   = err_ff ? '0 : INDEX_W'(pos_ff);
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      // A length write starts a new list.
      if (csr_write_en) begin
         list_len_in   = csr_write_data;
         total_in      = '0;
         clear_addr_in = '0;
         state_in      = ST_CLEAR;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         total_ff      <= '0;
         list_len_ff   <= LEN_W'(1024);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         total_ff      <= total_in;
         list_len_ff   <= list_len_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      node_ff      <= node_in;
      lo_ff        <= lo_in;
      half_ff      <= half_in;
      k_ff         <= k_in;
      err_ff       <= err_in;
      pos_ff       <= pos_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_removed_value    = rsp_value_ff;
   assign rsp_removed_position = rsp_pos_ff;
   assign rsp_rank_error       = rsp_err_ff;

endmodule

// ----- rtl/core/rsr_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port and one read port with a
// registered read. Self-contained, no package needed.
module rsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/rsr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for rank_select_and_remove, bound to the top level.
// Uses rsr_pkg for field widths and operation codes.
module rsr_checker
   import rsr_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_func,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [VALUE_W-1:0] rsp_removed_value,
   input logic [INDEX_W-1:0]        rsp_removed_position,
   input logic                      rsp_rank_error,
   input logic                      csr_write_en
);

   // A stalled response transaction holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_removed_value)
         && $stable(rsp_removed_position) && $stable(rsp_rank_error))
      else $error("stalled response changed");

   // An error response carries zero fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rank_error |-> rsp_removed_value == '0
         && rsp_removed_position == '0)
      else $error("error response with nonzero fields");

   // Reset starts the clearing pass with no pending response.
   assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block ready right after reset");

   // A length write starts the clearing pass.
   assert property (@(posedge clock)
      csr_write_en |=> !req_ready)
      else $error("block ready right after a length write");

   // A load transaction produces no response.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FUNC_LOAD) && !rsp_valid |=> !rsp_valid)
      else $error("load produced a response");

endmodule

bind rank_select_and_remove rsr_checker u_rsr_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rank_select_and_remove: loads, rank removals and list resets.
// Depends on rsr_pkg and the rank_select_and_remove RTL; needs no files or arguments.
module tb_top;
   import rsr_pkg::*;

   localparam int unsigned ITEM_TARGET  = 1550;
   localparam int unsigned PHASE_ITEMS  = 70;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned HOLD_ITEMS   = 12;
   localparam int unsigned DRAIN_MARGIN = 2 * LEVELS + 8;
   localparam int unsigned CYCLE_LIMIT  = 2000000;

   // One result transaction as the block should return it.
   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]        position;
      logic                      rank_error;
   } removal_result;

   // Mirror of the value store and removal count tree, plus the queue of results owed.
   class removal_scoreboard;
      logic signed [VALUE_W-1:0] stored_value [LIST_DEPTH];
      bit                        loaded [LIST_DEPTH];
      int unsigned               removed_count [TREE_DEPTH];
      int unsigned               removed_total = 0;
      int unsigned               length_cfg = 1024;
      removal_result             owed_results [$];
      int unsigned               error_count = 0;
      int unsigned               checked_count = 0;
      int unsigned               rank_error_count = 0;

      function int unsigned effective_length();
         return (length_cfg < LIST_DEPTH) ? length_cfg : LIST_DEPTH;
      endfunction

      function int unsigned present_count();
         int unsigned len;
         len = effective_length();
         return (removed_total <= len) ? len - removed_total : 0;
      endfunction

      function int unsigned pending_count();
         return owed_results.size();
      endfunction

      // A new list length starts a fresh list; stored values survive.
      function void set_length(input int unsigned len);
         length_cfg = len;
         removed_total = 0;
         foreach (removed_count[i]) removed_count[i] = 0;
      endfunction

      // Walk the count tree from the root to the position holding the given rank.
      function bit find_position(input int unsigned rank_in, output int unsigned pos);
         int unsigned len, k, node, lo, span, half, mid, lim, cap, used, live;
         pos = 0;
         len = effective_length();
         if (rank_in == 0 || rank_in > present_count()) return 1'b0;
         k = rank_in;
         node = 1;
         lo = 0;
         span = TREE_LEAVES;
         while (span > 1) begin
            half = span / 2;
            mid  = lo + half;
            lim  = (mid < len) ? mid : len;
            cap  = (lim > lo) ? lim - lo : 0;
            used = removed_count[2 * node];
            live = (cap > used) ? cap - used : 0;
            if (k <= live) begin
               node = 2 * node;
            end else begin
               k    = k - live;
               node = 2 * node + 1;
               lo   = mid;
            end
            span = half;
         end
         pos = lo;
         return 1'b1;
      endfunction

      // Apply an accepted request transaction and note the result it owes.
      function void note_request(input func_type op, input int unsigned idx,
                                 input logic signed [VALUE_W-1:0] val,
                                 input int unsigned rank_in);
         int unsigned   pos, node;
         removal_result owed;
         if (op == FUNC_LOAD) begin
            stored_value[idx] = val;
            loaded[idx] = 1'b1;
            return;
         end
         if (!find_position(rank_in, pos)) begin
            owed.value = '0;
            owed.position = '0;
            owed.rank_error = 1'b1;
         end else begin
            node = pos + TREE_LEAVES;
            removed_count[node] = 1;
            while (node > 1) begin
               node = node / 2;
               removed_count[node] = removed_count[2 * node] + removed_count[2 * node + 1];
            end
            removed_total++;
            owed.value = stored_value[pos];
            owed.position = pos[INDEX_W-1:0];
            owed.rank_error = 1'b0;
         end
         owed_results.push_back(owed);
      endfunction

      // Compare one result transaction with the oldest one owed.
      function void check_result(input logic signed [VALUE_W-1:0] value,
                                 input logic [INDEX_W-1:0] position, input logic rank_error);
         removal_result want;
         checked_count++;
         if (owed_results.size() == 0) begin
            $error("unexpected result: value %0d position %0d rank_error %0b",
                   value, position, rank_error);
            error_count++;
            return;
         end
         want = owed_results.pop_front();
         if (want.rank_error) rank_error_count++;
         if (rank_error !== want.rank_error) begin
            $error("rank_error: expected %0b, got %0b", want.rank_error, rank_error);
            error_count++;
         end
         if (value !== want.value) begin
            $error("removed_value: expected %0d, got %0d", want.value, value);
            error_count++;
         end
         if (position !== want.position) begin
            $error("removed_position: expected %0d, got %0d", want.position, position);
            error_count++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   func_type                  req_func;
   logic [INDEX_W-1:0]        req_load_index;
   logic signed [VALUE_W-1:0] req_load_value;
   logic [RANK_W-1:0]         req_rank;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [VALUE_W-1:0] rsp_removed_value;
   logic [INDEX_W-1:0]        rsp_removed_position;
   logic                      rsp_rank_error;
   logic                      csr_write_en;
   logic [LEN_W-1:0]          csr_write_data;

   removal_scoreboard sb = new;
   int unsigned       sent_items = 0;
   int unsigned       length_writes = 0;
   int unsigned       cycle_count = 0;
   bit                sender_eager = 1'b0;
   bit                hold_rsp_request = 1'b0;

   rank_select_and_remove dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_load_index       (req_load_index),
      .req_load_value       (req_load_value),
      .req_rank             (req_rank),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_removed_value    (rsp_removed_value),
      .rsp_removed_position (rsp_removed_position),
      .rsp_rank_error       (rsp_rank_error),
      .csr_write_en         (csr_write_en),
      .csr_write_data       (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: timeout after %0d cycles", cycle_count);
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Idle stretches: mostly a few cycles, sometimes much longer.
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 94) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 19))
         0: return {1'b0, {(VALUE_W-1){1'b1}}};
         1: return {1'b1, {(VALUE_W-1){1'b0}}};
         2: return '0;
         3: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Result sink: checks every result transaction and throttles rsp_ready.
   initial begin : result_sink
      int unsigned stall_left;
      int unsigned run_left;
      stall_left = 0;
      run_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
            sb.check_result(rsp_removed_value, rsp_removed_position, rsp_rank_error);
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left == 0 && run_left == 0) begin
            run_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) == 0) stall_left = idle_length();
         end
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            run_left--;
         end
      end
   end

   // Offer one request transaction and hold it until the block takes it.
   task automatic send_request(input func_type op, input logic [INDEX_W-1:0] idx,
                               input logic signed [VALUE_W-1:0] val,
                               input logic [RANK_W-1:0] rank_in);
      int unsigned gap;
      gap = 0;
      if (!sender_eager && $urandom_range(0, 99) >= 45) gap = idle_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= op;
      req_load_index <= idx;
      req_load_value <= val;
      req_rank       <= rank_in;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      sb.note_request(op, idx, val, rank_in);
      sent_items++;
   endtask

   task automatic send_load(input logic [INDEX_W-1:0] idx,
                            input logic signed [VALUE_W-1:0] val);
      send_request(FUNC_LOAD, idx, val, RANK_W'($urandom));
   endtask

   // A removal that would land on a never-loaded position gets that position loaded first.
   task automatic send_remove(input int unsigned rank_in);
      int unsigned pos;
      if (sb.find_position(rank_in, pos) && !sb.loaded[pos])
         send_load(pos[INDEX_W-1:0], random_value());
      send_request(FUNC_REMOVE, INDEX_W'($urandom), random_value(), rank_in[RANK_W-1:0]);
   endtask

   // Pick a rank that hits a present entry, or one out of range.
   task automatic send_random_remove(input bit in_range);
      int unsigned live;
      live = sb.present_count();
      if (in_range && live != 0)
         send_remove($urandom_range(1, live));
      else if ($urandom_range(0, 3) == 0)
         send_remove(0);
      else
         send_remove($urandom_range(live + 1, (1 << RANK_W) - 1));
   endtask

   task automatic send_random_item();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30)
         send_load(INDEX_W'($urandom), random_value());
      else
         send_random_remove(r < 88);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_count() != 0) @(posedge clock);
   endtask

   // Length writes happen only with the block drained; loads leave no result to wait on.
   task automatic program_length(input int unsigned len);
      wait_for_results();
      repeat (DRAIN_MARGIN) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= len[LEN_W-1:0];
      @(posedge clock);
      csr_write_en   <= 1'b0;
      sb.set_length(len);
      length_writes++;
   endtask

   // The first phases hit the register extremes; later ones are mostly short lists.
   function automatic int unsigned pick_length(input int unsigned phase);
      int unsigned r;
      case (phase)
         0: return 0;
         1: return 1;
         2: return (1 << LEN_W) - 1;
         3: return LIST_DEPTH;
         4: return 2;
         default: begin
            r = $urandom_range(0, 99);
            if (r < 75) return $urandom_range(3, 64);
            if (r < 88) return $urandom_range(65, LIST_DEPTH - 1);
            return $urandom_range(LIST_DEPTH + 1, (1 << LEN_W) - 1);
         end
      endcase
   endfunction

   initial begin : stimulus
      int unsigned phase;
      int unsigned phase_start;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_func       <= FUNC_LOAD;
      req_load_index <= '0;
      req_load_value <= '0;
      req_rank       <= '0;
      csr_write_en   <= 1'b0;
      csr_write_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset length: rank extremes, value extremes, removed slots.
      send_remove(0);
      send_remove((1 << RANK_W) - 1);
      send_load(0, {1'b0, {(VALUE_W-1){1'b1}}});
      send_load(LIST_DEPTH - 1, {1'b1, {(VALUE_W-1){1'b0}}});
      send_load(1, '0);
      send_load(2, '1);
      send_load(LIST_DEPTH - 2, {(VALUE_W/2){2'b10}});
      send_load(LIST_DEPTH / 2, {(VALUE_W/2){2'b01}});
      send_remove(1);
      send_remove(LIST_DEPTH - 1);
      send_remove(LIST_DEPTH - 2);
      send_remove(LIST_DEPTH - 2);
      // Reloading a removed slot must not bring it back.
      send_load(0, 64'h0123_4567_89ab_cdef);
      send_remove(1);
      send_remove(1);
      send_remove(LIST_DEPTH / 2 - 2);

      // Random phases, each under a freshly written list length.
      phase = 0;
      while (sent_items < ITEM_TARGET) begin
         program_length(pick_length(phase));
         sender_eager = ($urandom_range(0, 3) == 0);
         phase_start = sent_items;
         if (phase % 6 == 3) begin
            // Stall the result side while removals keep coming, so the input backs up.
            hold_rsp_request = 1'b1;
            sender_eager = 1'b1;
            repeat (HOLD_ITEMS) send_random_remove(1'b1);
            sender_eager = 1'b0;
         end
         while (sent_items - phase_start < PHASE_ITEMS && sent_items < ITEM_TARGET) begin
            if (phase % 5 == 2 && sent_items - phase_start == PHASE_ITEMS / 2)
               wait_for_results();
            send_random_item();
         end
         phase++;
      end

      wait_for_results();
      repeat (DRAIN_MARGIN) @(posedge clock);

      $display("tb_top: %0d transactions sent under %0d list lengths (reset one included)",
               sent_items, length_writes + 1);
      $display("tb_top: %0d results checked, %0d of them rank errors, %0d mismatches",
               sb.checked_count, sb.rank_error_count, sb.error_count);
      if (sb.error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// ----- rank_select_and_remove.f -----
rtl/core/rsr_pkg.sv
rtl/core/rsr_ram.sv
rtl/core/rank_select_and_remove.sv
rtl/core/rsr_checker.sv
tb/sv/tb_top.sv
